/* sv/tpg_pkg.sv */
`default_nettype none
package tpg_pkg;

  localparam int unsigned TEMP_W = 10;
  localparam int unsigned LOAD_W = 16;

  localparam logic [TEMP_W-1:0] CPU_DEFAULT_DEG     = TEMP_W'(40);
  localparam logic [TEMP_W-1:0] BATTERY_DEFAULT_DEG = TEMP_W'(35);
  localparam logic [17:0]       BATTERY_MILLI_ABOVE = 18'd10000;
  localparam logic [17:0]       BATTERY_DECI_ABOVE  = 18'd100;

  // Reciprocals for the divisions by 1000 and by 10.
  localparam int unsigned       DIV1000_SHIFT = 28;
  localparam logic [18:0]       DIV1000_MUL   = 19'd268436;
  localparam int unsigned       DIV10_SHIFT   = 17;
  localparam logic [13:0]       DIV10_MUL     = 14'd13108;

  localparam logic [TEMP_W-1:0] COOL_CPU_MAX      = TEMP_W'(51);
  localparam logic [TEMP_W-1:0] COOL_BATTERY_MAX  = TEMP_W'(43);
  localparam logic [TEMP_W-1:0] WARM_CPU_MIN      = TEMP_W'(48);
  localparam logic [TEMP_W-1:0] WARM_BATTERY_MIN  = TEMP_W'(41);
  localparam logic [TEMP_W-1:0] RISE_CPU_MIN      = TEMP_W'(51);
  localparam logic [TEMP_W-1:0] RISE_BATTERY_MIN  = TEMP_W'(44);
  localparam logic [TEMP_W-1:0] FALL_CPU_BELOW    = TEMP_W'(47);
  localparam logic [TEMP_W-1:0] FALL_BATTERY_BELOW = TEMP_W'(41);
  localparam logic [TEMP_W-1:0] MILD_CPU_MIN      = TEMP_W'(43);
  localparam logic [TEMP_W-1:0] MILD_BATTERY_MIN  = TEMP_W'(39);

  localparam logic [6:0] GPU_GAME_MIN = 7'd15;

  localparam logic [1:0] TIER_COOL = 2'd0;
  localparam logic [1:0] TIER_MILD = 2'd1;
  localparam logic [1:0] TIER_WARM = 2'd2;
  localparam logic [1:0] TIER_HOT  = 2'd3;

  typedef enum logic [2:0] {
    PROF_SLEEP       = 3'd0,
    PROF_INTERACTIVE = 3'd1,
    PROF_TOUCH       = 3'd2,
    PROF_GAMING      = 3'd3,
    PROF_THERMAL     = 3'd4,
    PROF_NONE        = 3'd7
  } tpg_profile_t;

  localparam logic [2:0] CFG_HOT_CPU       = 3'd0;
  localparam logic [2:0] CFG_HOT_BATTERY   = 3'd1;
  localparam logic [2:0] CFG_THERMAL_HOLD  = 3'd2;
  localparam logic [2:0] CFG_CRITICAL_CPU  = 3'd3;
  localparam logic [2:0] CFG_GPU_GAME      = 3'd4;
  localparam logic [2:0] CFG_HEAVY_LOAD    = 3'd5;
  localparam logic [2:0] CFG_LOAD_JUMP     = 3'd6;
  localparam logic [2:0] CFG_TOUCH_HOLD    = 3'd7;

  typedef struct packed {
    logic [6:0]        hot_cpu_limit;
    logic [6:0]        hot_battery_limit;
    logic [3:0]        thermal_hold_length;
    logic [6:0]        critical_cpu_limit;
    logic [6:0]        gpu_game_load;
    logic [LOAD_W-1:0] heavy_load_level;
    logic [LOAD_W-1:0] load_jump_level;
    logic [3:0]        touch_hold_length;
  } tpg_cfg_t;

  localparam tpg_cfg_t CFG_RESET = '{
    hot_cpu_limit:       7'd58,
    hot_battery_limit:   7'd47,
    thermal_hold_length: 4'd4,
    critical_cpu_limit:  7'd60,
    gpu_game_load:       7'd35,
    heavy_load_level:    16'd1200,
    load_jump_level:     16'd150,
    touch_hold_length:   4'd3
  };

  typedef struct packed {
    tpg_profile_t profile;
    logic [1:0]   tier;
    logic         apply_now;
  } tpg_decision_t;

  typedef struct packed {
    logic [21:0] little_min_khz;
    logic [21:0] little_max_khz;
    logic [21:0] big_min_khz;
    logic [21:0] big_max_khz;
    logic [19:0] gpu_floor_khz;
    logic [11:0] up_rate_us;
    logic [11:0] down_rate_us;
    logic        boost_top_app;
  } tpg_freq_t;

  function automatic tpg_freq_t tpg_table(tpg_profile_t profile, logic [1:0] tier);
    tpg_freq_t f;
    f.little_min_khz = 22'd700000;
    f.little_max_khz = 22'd2000000;
    f.big_min_khz    = 22'd1000000;
    f.big_max_khz    = 22'd2200000;
    f.gpu_floor_khz  = 20'd450000;
    f.up_rate_us     = 12'd0;
    f.down_rate_us   = 12'd1000;
    f.boost_top_app  = 1'b1;
    case (profile)
      PROF_SLEEP: begin
        f.little_min_khz = 22'd500000;
        f.little_max_khz = 22'd1450000;
        f.big_min_khz    = 22'd725000;
        f.big_max_khz    = 22'd1300000;
        f.up_rate_us     = 12'd2000;
        f.down_rate_us   = 12'd500;
        f.boost_top_app  = 1'b0;
        f.gpu_floor_khz  = 20'd300000;
      end
      PROF_INTERACTIVE: begin
        f.little_min_khz = 22'd900000;
        f.big_min_khz    = 22'd1100000;
        f.big_max_khz    = (tier == TIER_HOT) ? 22'd2000000 : 22'd2200000;
        f.gpu_floor_khz  = 20'd550000;
      end
      PROF_TOUCH: begin
        f.little_min_khz = 22'd1200000;
        f.big_min_khz    = 22'd1500000;
        f.gpu_floor_khz  = 20'd700000;
      end
      PROF_GAMING: begin
        f.little_min_khz = 22'd1200000;
        f.big_min_khz    = 22'd1600000;
        f.down_rate_us   = 12'd2500;
        f.gpu_floor_khz  = (tier >= TIER_WARM) ? 20'd700000 : 20'd800000;
      end
      default: begin
        f.big_max_khz    = 22'd2000000;
      end
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

/* sv/thermal_profile_governor_top.sv */
// Thermal profile governor.
// The input channel carries one sensor tick per transaction: CPU and battery
// temperatures, screen and gaming-lock flags, GPU load and centi-load average.
// Every accepted tick yields exactly one result transaction on the output
// channel with the profile, thermal tier, change flag and the frequency and
// rate-limit values of the chosen profile.
// The configuration channel writes one of eight threshold registers per
// transaction and is always ready; write it only while no tick is in flight.
// A tick passes an input register and then a result register; one tick can be
// accepted every cycle as long as the receiver does not stall the result register.
// The thermal, hold, boost, last-load and active-profile state is updated in the same
// cycle the tick leaves the input register.
// When the receiver stalls, the result register holds and the input register
// still takes one more tick; after that in_ready drops until out_ready returns.
// Synchronous reset restores the register defaults, clears the thermal state
// and marks no profile as active, so the first result always flags a change.
`default_nettype none
module thermal_profile_governor_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [18:0] in_cpu_millidegrees,
  input  wire logic signed [18:0] in_battery_raw,
  input  wire logic               in_screen_lit,
  input  wire logic               in_gaming_lock,
  input  wire logic [6:0]         in_gpu_busy,
  input  wire logic [15:0]        in_load_centi,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_profile,
  output logic [1:0]              out_tier,
  output logic                    out_apply_now,
  output logic [21:0]             out_little_min_khz,
  output logic [21:0]             out_little_max_khz,
  output logic [21:0]             out_big_min_khz,
  output logic [21:0]             out_big_max_khz,
  output logic [19:0]             out_gpu_floor_khz,
  output logic [11:0]             out_up_rate_us,
  output logic [11:0]             out_down_rate_us,
  output logic                    out_boost_top_app,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import tpg_pkg::*;

  tpg_cfg_t          cfg;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [18:0] s1_cpu_r;
  logic signed [18:0] s1_battery_r;
  logic              s1_screen_r;
  logic              s1_lock_r;
  logic [6:0]        s1_gpu_r;
  logic [LOAD_W-1:0] s1_load_r;
  logic              out_adv;
  logic              fire;
  logic [TEMP_W-1:0] cpu_deg;
  logic [TEMP_W-1:0] battery_deg;
  tpg_decision_t     decision;
  tpg_decision_t     dec_r;
  tpg_freq_t         freq_r;

  tpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;
  assign fire     = s1_valid_r && out_adv;

  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cpu_r     <= in_cpu_millidegrees;
      s1_battery_r <= in_battery_raw;
      s1_screen_r  <= in_screen_lit;
      s1_lock_r    <= in_gaming_lock;
      s1_gpu_r     <= in_gpu_busy;
      s1_load_r    <= in_load_centi;
    end
  end

  tpg_temp_norm u_norm (
    .cpu_millidegrees (s1_cpu_r),
    .battery_raw      (s1_battery_r),
    .cpu_deg          (cpu_deg),
    .battery_deg      (battery_deg)
  );

  tpg_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .cfg         (cfg),
    .cpu_deg     (cpu_deg),
    .battery_deg (battery_deg),
    .screen_lit  (s1_screen_r),
    .gaming_lock (s1_lock_r),
    .gpu_busy    (s1_gpu_r),
    .load_centi  (s1_load_r),
    .decision    (decision)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      dec_r  <= decision;
      freq_r <= tpg_table(decision.profile, decision.tier);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_profile        = dec_r.profile;
  assign out_tier           = dec_r.tier;
  assign out_apply_now      = dec_r.apply_now;
  assign out_little_min_khz = freq_r.little_min_khz;
  assign out_little_max_khz = freq_r.little_max_khz;
  assign out_big_min_khz    = freq_r.big_min_khz;
  assign out_big_max_khz    = freq_r.big_max_khz;
  assign out_gpu_floor_khz  = freq_r.gpu_floor_khz;
  assign out_up_rate_us     = freq_r.up_rate_us;
  assign out_down_rate_us   = freq_r.down_rate_us;
  assign out_boost_top_app  = freq_r.boost_top_app;

endmodule
`default_nettype wire

/* sv/tpg_cfg_regs.sv */
`default_nettype none
module tpg_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  output tpg_pkg::tpg_cfg_t     cfg
);
  import tpg_pkg::*;

  tpg_cfg_t cfg_r;
  tpg_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_HOT_CPU:      cfg_nxt.hot_cpu_limit       = cfg_data[6:0];
        CFG_HOT_BATTERY:  cfg_nxt.hot_battery_limit   = cfg_data[6:0];
        CFG_THERMAL_HOLD: cfg_nxt.thermal_hold_length = cfg_data[3:0];
        CFG_CRITICAL_CPU: cfg_nxt.critical_cpu_limit  = cfg_data[6:0];
        CFG_GPU_GAME:     cfg_nxt.gpu_game_load       = cfg_data[6:0];
        CFG_HEAVY_LOAD:   cfg_nxt.heavy_load_level    = cfg_data;
        CFG_LOAD_JUMP:    cfg_nxt.load_jump_level     = cfg_data;
        CFG_TOUCH_HOLD:   cfg_nxt.touch_hold_length   = cfg_data[3:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/tpg_temp_norm.sv */
`default_nettype none
module tpg_temp_norm (
  input  wire logic signed [18:0]          cpu_millidegrees,
  input  wire logic signed [18:0]          battery_raw,
  output logic [tpg_pkg::TEMP_W-1:0]       cpu_deg,
  output logic [tpg_pkg::TEMP_W-1:0]       battery_deg
);
  import tpg_pkg::*;

  logic [36:0] cpu_prod;
  logic [8:0]  cpu_quot;
  logic [17:0] bat_mag;
  logic [36:0] bat_prod1000;
  logic [27:0] bat_prod10;
  logic [8:0]  bat_quot1000;
  logic [10:0] bat_quot10;

  // Multiplication by a rounded-up reciprocal gives the exact floor over the input range.
  assign cpu_prod = 37'(cpu_millidegrees[17:0]) * 37'(DIV1000_MUL);
  assign cpu_quot = cpu_prod[DIV1000_SHIFT +: 9];

  always_comb begin
    if (cpu_millidegrees[18] || (cpu_quot == 9'd0)) begin
      cpu_deg = CPU_DEFAULT_DEG;
    end else begin
      cpu_deg = TEMP_W'(cpu_quot);
    end
  end

  assign bat_mag      = battery_raw[17:0];
  assign bat_prod1000 = 37'(bat_mag) * 37'(DIV1000_MUL);
  assign bat_quot1000 = bat_prod1000[DIV1000_SHIFT +: 9];
  assign bat_prod10   = 28'(bat_mag[13:0]) * 28'(DIV10_MUL);
  assign bat_quot10   = bat_prod10[DIV10_SHIFT +: 11];

  always_comb begin
    if (battery_raw[18] || (bat_mag == 18'd0)) begin
      battery_deg = BATTERY_DEFAULT_DEG;
    end else if (bat_mag > BATTERY_MILLI_ABOVE) begin
      battery_deg = TEMP_W'(bat_quot1000);
    end else if (bat_mag > BATTERY_DECI_ABOVE) begin
      battery_deg = bat_quot10[TEMP_W-1:0];
    end else begin
      battery_deg = bat_mag[TEMP_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* sv/tpg_core.sv */
`default_nettype none
module tpg_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fire,
  input  wire tpg_pkg::tpg_cfg_t           cfg,
  input  wire logic [tpg_pkg::TEMP_W-1:0]  cpu_deg,
  input  wire logic [tpg_pkg::TEMP_W-1:0]  battery_deg,
  input  wire logic                        screen_lit,
  input  wire logic                        gaming_lock,
  input  wire logic [6:0]                  gpu_busy,
  input  wire logic [tpg_pkg::LOAD_W-1:0]  load_centi,
  output tpg_pkg::tpg_decision_t           decision
);
  import tpg_pkg::*;

  logic [1:0]        tier_r, tier_nxt;
  logic [3:0]        hold_r, hold_nxt;
  logic [3:0]        boost_r, boost_nxt;
  logic [LOAD_W-1:0] last_load_r;
  tpg_profile_t      active_r, profile_nxt;

  logic [TEMP_W-1:0] c;
  logic [TEMP_W-1:0] b;
  logic              hot;
  logic              gaming;
  logic              jump;

  assign c = cpu_deg;
  assign b = battery_deg;
  assign hot = (c >= TEMP_W'(cfg.hot_cpu_limit)) || (b >= TEMP_W'(cfg.hot_battery_limit));

  always_comb begin
    tier_nxt = tier_r;
    hold_nxt = hold_r;
    if (hot) begin
      tier_nxt = TIER_HOT;
      hold_nxt = cfg.thermal_hold_length;
    end else if (hold_r != 4'd0) begin
      tier_nxt = TIER_HOT;
      hold_nxt = hold_r - 4'd1;
    end else if (tier_r == TIER_HOT) begin
      if ((c <= COOL_CPU_MAX) && (b <= COOL_BATTERY_MAX)) begin
        tier_nxt = ((c >= WARM_CPU_MIN) || (b >= WARM_BATTERY_MIN)) ? TIER_WARM : TIER_MILD;
      end
    end else if ((c >= RISE_CPU_MIN) || (b >= RISE_BATTERY_MIN)) begin
      tier_nxt = TIER_WARM;
    end else if (tier_r == TIER_WARM) begin
      if ((c < FALL_CPU_BELOW) && (b < FALL_BATTERY_BELOW)) begin
        tier_nxt = ((c >= MILD_CPU_MIN) || (b >= MILD_BATTERY_MIN)) ? TIER_MILD : TIER_COOL;
      end
    end else if ((c >= MILD_CPU_MIN) || (b >= MILD_BATTERY_MIN)) begin
      tier_nxt = TIER_MILD;
    end else begin
      tier_nxt = TIER_COOL;
    end
  end

  assign gaming = gaming_lock || (gpu_busy >= cfg.gpu_game_load) ||
                  ((gpu_busy >= GPU_GAME_MIN) && (load_centi >= cfg.heavy_load_level));
  assign jump   = (load_centi > last_load_r) &&
                  ((load_centi - last_load_r) > cfg.load_jump_level);

  always_comb begin
    boost_nxt   = 4'd0;
    profile_nxt = PROF_INTERACTIVE;
    if (!screen_lit) begin
      profile_nxt = PROF_SLEEP;
    end else if ((tier_nxt == TIER_HOT) && (c >= TEMP_W'(cfg.critical_cpu_limit))) begin
      profile_nxt = PROF_THERMAL;
    end else if (gaming) begin
      profile_nxt = PROF_GAMING;
    end else if (jump || (boost_r != 4'd0)) begin
      if ((active_r != PROF_TOUCH) && (boost_r == 4'd0)) begin
        boost_nxt = cfg.touch_hold_length;
      end else if (boost_r != 4'd0) begin
        boost_nxt = boost_r - 4'd1;
      end
      profile_nxt = (boost_nxt != 4'd0) ? PROF_TOUCH : PROF_INTERACTIVE;
    end
  end

  assign decision.profile   = profile_nxt;
  assign decision.tier      = tier_nxt;
  assign decision.apply_now = (profile_nxt != active_r) || (tier_nxt != tier_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tier_r      <= TIER_COOL;
      hold_r      <= 4'd0;
      boost_r     <= 4'd0;
      last_load_r <= '0;
      active_r    <= PROF_NONE;
    end else if (fire) begin
      tier_r      <= tier_nxt;
      hold_r      <= hold_nxt;
      boost_r     <= boost_nxt;
      last_load_r <= load_centi;
      active_r    <= profile_nxt;
    end
  end

endmodule
`default_nettype wire

/* bench/thermal_profile_governor_top_tb.sv */
`timescale 1ns / 1ps
module thermal_profile_governor_top_tb;
  import tpg_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic signed [18:0] cpu;
    logic signed [18:0] batt;
    logic               screen;
    logic               lock;
    logic [6:0]         gpu;
    logic [15:0]        load;
  } tick_t;

  typedef struct {
    tpg_profile_t profile;
    logic [1:0]   tier;
    logic         apply_now;
    tpg_freq_t    freq;
  } tick_outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [18:0] in_cpu_millidegrees = '0;
  logic signed [18:0] in_battery_raw = '0;
  logic               in_screen_lit = 1'b0;
  logic               in_gaming_lock = 1'b0;
  logic [6:0]         in_gpu_busy = '0;
  logic [15:0]        in_load_centi = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_profile;
  logic [1:0]         out_tier;
  logic               out_apply_now;
  logic [21:0]        out_little_min_khz;
  logic [21:0]        out_little_max_khz;
  logic [21:0]        out_big_min_khz;
  logic [21:0]        out_big_max_khz;
  logic [19:0]        out_gpu_floor_khz;
  logic [11:0]        out_up_rate_us;
  logic [11:0]        out_down_rate_us;
  logic               out_boost_top_app;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  int load_walk = 0;

  tpg_cfg_t      limits_m;
  logic [1:0]    tier_m;
  logic [3:0]    hold_m;
  logic [3:0]    boost_m;
  logic [15:0]   last_load_m;
  tpg_profile_t  active_m;
  tick_outcome_t pending_decisions[$];
  tick_outcome_t want_outcome;

  thermal_profile_governor_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cpu_millidegrees (in_cpu_millidegrees),
    .in_battery_raw      (in_battery_raw),
    .in_screen_lit       (in_screen_lit),
    .in_gaming_lock      (in_gaming_lock),
    .in_gpu_busy         (in_gpu_busy),
    .in_load_centi       (in_load_centi),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_profile         (out_profile),
    .out_tier            (out_tier),
    .out_apply_now       (out_apply_now),
    .out_little_min_khz  (out_little_min_khz),
    .out_little_max_khz  (out_little_max_khz),
    .out_big_min_khz     (out_big_min_khz),
    .out_big_max_khz     (out_big_max_khz),
    .out_gpu_floor_khz   (out_gpu_floor_khz),
    .out_up_rate_us      (out_up_rate_us),
    .out_down_rate_us    (out_down_rate_us),
    .out_boost_top_app   (out_boost_top_app),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic decide_tick(tick_t t);
    int            c;
    int            b;
    logic [1:0]    nt;
    tpg_profile_t  p;
    tick_outcome_t r;
    c = int'(t.cpu) / 1000;
    if (c <= 0) c = 40;
    b = int'(t.batt);
    if (b > 10000) b = b / 1000;
    else if (b > 100) b = b / 10;
    if (b <= 0) b = 35;

    nt = tier_m;
    if (c >= int'(limits_m.hot_cpu_limit) || b >= int'(limits_m.hot_battery_limit)) begin
      nt = TIER_HOT;
      hold_m = limits_m.thermal_hold_length;
    end else if (hold_m != 4'd0) begin
      hold_m = hold_m - 4'd1;
      nt = TIER_HOT;
    end else if (tier_m == TIER_HOT) begin
      if (c <= 51 && b <= 43) nt = (c >= 48 || b >= 41) ? TIER_WARM : TIER_MILD;
    end else if (c >= 51 || b >= 44) begin
      nt = TIER_WARM;
    end else if (tier_m == TIER_WARM) begin
      if (c < 47 && b < 41) nt = (c >= 43 || b >= 39) ? TIER_MILD : TIER_COOL;
    end else if (c >= 43 || b >= 39) begin
      nt = TIER_MILD;
    end else begin
      nt = TIER_COOL;
    end

    if (!t.screen) begin
      p = PROF_SLEEP;
      boost_m = 4'd0;
    end else if (nt == TIER_HOT && c >= int'(limits_m.critical_cpu_limit)) begin
      p = PROF_THERMAL;
      boost_m = 4'd0;
    end else if (t.lock || t.gpu >= limits_m.gpu_game_load ||
                 (t.gpu >= 7'd15 && t.load >= limits_m.heavy_load_level)) begin
      p = PROF_GAMING;
      boost_m = 4'd0;
    end else if ((int'(t.load) - int'(last_load_m)) > int'(limits_m.load_jump_level) ||
                 boost_m != 4'd0) begin
      if (active_m != PROF_TOUCH && boost_m == 4'd0) boost_m = limits_m.touch_hold_length;
      else if (boost_m != 4'd0) boost_m = boost_m - 4'd1;
      p = (boost_m != 4'd0) ? PROF_TOUCH : PROF_INTERACTIVE;
    end else begin
      p = PROF_INTERACTIVE;
      boost_m = 4'd0;
    end
    last_load_m = t.load;

    r.apply_now = (p != active_m || nt != tier_m);
    r.profile = p;
    r.tier = nt;
    active_m = p;
    tier_m = nt;

    r.freq.little_max_khz = 22'd2000000;
    r.freq.big_max_khz    = 22'd2200000;
    r.freq.up_rate_us     = 12'd0;
    r.freq.down_rate_us   = 12'd1000;
    r.freq.boost_top_app  = 1'b1;
    case (p)
      PROF_SLEEP: begin
        r.freq.little_min_khz = 22'd500000;
        r.freq.little_max_khz = 22'd1450000;
        r.freq.big_min_khz    = 22'd725000;
        r.freq.big_max_khz    = 22'd1300000;
        r.freq.up_rate_us     = 12'd2000;
        r.freq.down_rate_us   = 12'd500;
        r.freq.boost_top_app  = 1'b0;
        r.freq.gpu_floor_khz  = 20'd300000;
      end
      PROF_INTERACTIVE: begin
        r.freq.little_min_khz = 22'd900000;
        r.freq.big_min_khz    = 22'd1100000;
        r.freq.big_max_khz    = (nt == TIER_HOT) ? 22'd2000000 : 22'd2200000;
        r.freq.gpu_floor_khz  = 20'd550000;
      end
      PROF_TOUCH: begin
        r.freq.little_min_khz = 22'd1200000;
        r.freq.big_min_khz    = 22'd1500000;
        r.freq.gpu_floor_khz  = 20'd700000;
      end
      PROF_GAMING: begin
        r.freq.little_min_khz = 22'd1200000;
        r.freq.big_min_khz    = 22'd1600000;
        r.freq.down_rate_us   = 12'd2500;
        r.freq.gpu_floor_khz  = (nt >= TIER_WARM) ? 20'd700000 : 20'd800000;
      end
      default: begin
        r.freq.little_min_khz = 22'd700000;
        r.freq.big_min_khz    = 22'd1000000;
        r.freq.big_max_khz    = 22'd2000000;
        r.freq.gpu_floor_khz  = 20'd450000;
      end
    endcase
    pending_decisions.push_back(r);
  endtask

  function automatic tick_t reading(int cpu, int batt, bit screen, bit lock, int gpu, int load);
    tick_t t;
    t.cpu = 19'(cpu);
    t.batt = 19'(batt);
    t.screen = screen;
    t.lock = lock;
    t.gpu = 7'(gpu);
    t.load = 16'(load);
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    case ($urandom_range(9))
      0: t.cpu = 19'($urandom);
      1: t.cpu = 19'(int'($urandom_range(3000)) - 1500);
      2: t.cpu = 19'($urandom_range(66000, 56000));
      default: t.cpu = 19'($urandom_range(56000, 36000));
    endcase
    case ($urandom_range(3))
      0: t.batt = 19'($urandom);
      1: t.batt = 19'(int'($urandom_range(60)) - 5);
      2: t.batt = 19'($urandom_range(520, 95));
      default: t.batt = 19'($urandom_range(52000, 9995));
    endcase
    case ($urandom_range(7))
      0: load_walk = int'($urandom_range(65535));
      1, 2: load_walk = load_walk + int'($urandom_range(400));
      default: load_walk = load_walk + int'($urandom_range(120)) - 60;
    endcase
    if (load_walk < 0) load_walk = 0;
    else if (load_walk > 65535) load_walk = 65535;
    t.load = 16'(load_walk);
    t.screen = ($urandom_range(9) != 0);
    t.lock = ($urandom_range(9) == 0);
    t.gpu = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(40));
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cpu_millidegrees <= t.cpu;
    in_battery_raw      <= t.batt;
    in_screen_lit       <= t.screen;
    in_gaming_lock      <= t.lock;
    in_gpu_busy         <= t.gpu;
    in_load_centi       <= t.load;
    do @(posedge clk); while (!in_ready);
    decide_tick(t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HOT_CPU:      limits_m.hot_cpu_limit = data[6:0];
      CFG_HOT_BATTERY:  limits_m.hot_battery_limit = data[6:0];
      CFG_THERMAL_HOLD: limits_m.thermal_hold_length = data[3:0];
      CFG_CRITICAL_CPU: limits_m.critical_cpu_limit = data[6:0];
      CFG_GPU_GAME:     limits_m.gpu_game_load = data[6:0];
      CFG_HEAVY_LOAD:   limits_m.heavy_load_level = data;
      CFG_LOAD_JUMP:    limits_m.load_jump_level = data;
      default:          limits_m.touch_hold_length = data[3:0];
    endcase
  endtask

  task automatic load_config(tpg_cfg_t limits);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_HOT_CPU, {junk[15:7], limits.hot_cpu_limit});
    write_reg(CFG_HOT_BATTERY, {junk[8:0], limits.hot_battery_limit});
    write_reg(CFG_THERMAL_HOLD, {junk[11:0], limits.thermal_hold_length});
    write_reg(CFG_CRITICAL_CPU, {junk[12:4], limits.critical_cpu_limit});
    write_reg(CFG_GPU_GAME, {junk[14:6], limits.gpu_game_load});
    write_reg(CFG_HEAVY_LOAD, limits.heavy_load_level);
    write_reg(CFG_LOAD_JUMP, limits.load_jump_level);
    write_reg(CFG_TOUCH_HOLD, {junk[15:4], limits.touch_hold_length});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_temperature_scaling();
    send_tick(reading(30000, 30, 1, 0, 0, 0));
    send_tick(reading(-262144, -262144, 1, 0, 0, 0));
    send_tick(reading(999, 0, 1, 0, 0, 0));
    send_tick(reading(44000, 101, 1, 0, 0, 0));
    send_tick(reading(40000, 10001, 1, 0, 0, 0));
  endtask

  task automatic test_tier_hysteresis();
    send_tick(reading(52000, 350, 1, 0, 0, 0));
    send_tick(reading(45000, 30, 1, 0, 0, 0));
    send_tick(reading(262143, 30, 1, 0, 0, 0));
    send_tick(reading(30000, 200000, 1, 0, 0, 0));
    repeat (4) send_tick(reading(30000, 30, 1, 0, 0, 0));
    send_tick(reading(49000, 30, 1, 0, 0, 0));
  endtask

  task automatic test_profile_selection();
    send_tick(reading(49000, 30, 0, 0, 0, 0));
    send_tick(reading(49000, 30, 1, 1, 0, 0));
    send_tick(reading(30000, 30, 1, 0, 127, 65535));
    send_tick(reading(30000, 30, 1, 0, 15, 1200));
    send_tick(reading(30000, 30, 1, 0, 14, 0));
    repeat (4) send_tick(reading(30000, 30, 1, 0, 0, 200));
  endtask

  task automatic test_zero_holds();
    tpg_cfg_t limits;
    limits = CFG_RESET;
    limits.thermal_hold_length = 4'd0;
    limits.touch_hold_length = 4'd0;
    wait_drained();
    load_config(limits);
    send_tick(reading(60000, 30, 1, 0, 0, 0));
    send_tick(reading(30000, 30, 1, 0, 0, 0));
    send_tick(reading(30000, 30, 1, 0, 0, 500));
  endtask

  task automatic test_random_settings();
    tpg_cfg_t limits;
    int       ph;
    int       n;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: limits = CFG_RESET;
        1: limits = '0;
        2: limits = '1;
        default: begin
          limits.hot_cpu_limit       = 7'($urandom_range(70, 40));
          limits.hot_battery_limit   = 7'($urandom_range(60, 35));
          limits.thermal_hold_length = 4'($urandom);
          limits.critical_cpu_limit  = 7'($urandom_range(75, 45));
          limits.gpu_game_load       = 7'($urandom_range(100));
          limits.heavy_load_level    = ($urandom_range(3) == 0) ? 16'($urandom) :
                                       16'($urandom_range(3000));
          limits.load_jump_level     = ($urandom_range(3) == 0) ? 16'($urandom) :
                                       16'($urandom_range(400));
          limits.touch_hold_length   = 4'($urandom);
        end
      endcase
      wait_drained();
      load_config(limits);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 81; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 81; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      for (n = 0; n < 68; n++) begin
        if (ph == 5 && n == 34) wait_drained();
        send_tick(random_tick());
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
    if (rst_n && out_valid && out_ready) begin
      if (pending_decisions.size() == 0) begin
        report("result transaction with no expected result");
      end else begin
        want_outcome = pending_decisions.pop_front();
        check_field("profile", out_profile, want_outcome.profile);
        check_field("tier", out_tier, want_outcome.tier);
        check_field("apply_now", out_apply_now, want_outcome.apply_now);
        check_field("little_min_khz", out_little_min_khz, want_outcome.freq.little_min_khz);
        check_field("little_max_khz", out_little_max_khz, want_outcome.freq.little_max_khz);
        check_field("big_min_khz", out_big_min_khz, want_outcome.freq.big_min_khz);
        check_field("big_max_khz", out_big_max_khz, want_outcome.freq.big_max_khz);
        check_field("gpu_floor_khz", out_gpu_floor_khz, want_outcome.freq.gpu_floor_khz);
        check_field("up_rate_us", out_up_rate_us, want_outcome.freq.up_rate_us);
        check_field("down_rate_us", out_down_rate_us, want_outcome.freq.down_rate_us);
        check_field("boost_top_app", out_boost_top_app, want_outcome.freq.boost_top_app);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    limits_m    = CFG_RESET;
    tier_m      = TIER_COOL;
    hold_m      = 4'd0;
    boost_m     = 4'd0;
    last_load_m = 16'd0;
    active_m    = PROF_NONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_temperature_scaling();
    test_tier_hysteresis();
    test_profile_selection();
    test_zero_holds();
    test_random_settings();
    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tpg_pkg.sv
sv/tpg_cfg_regs.sv
sv/tpg_temp_norm.sv
sv/tpg_core.sv
sv/thermal_profile_governor_top.sv
bench/thermal_profile_governor_top_tb.sv
